### hw/rtl/mvts_pkg.sv
//------------------------------------------------------------------------------
// mvts_pkg
// Shared types and constants of the multi-voice tone synthesizer.
//------------------------------------------------------------------------------
package mvts_pkg;

	localparam int VOICES_DEF = 16;

	localparam logic [16:0] FULL_Q16   = 17'd65536;
	localparam logic [15:0] AMP_Q16    = 16'd45875;
	localparam logic signed [16:0] PULSE_HI = 17'sd32767;
	localparam logic signed [16:0] PULSE_LO = -17'sd10813;
	localparam logic [11:0] CUTOFF_Q15 = 12'd3277;
	localparam logic [11:0] VOLUME_Q16 = 12'd3277;
	localparam logic [15:0] LFSR_TAPS  = 16'hB400;
	localparam logic [15:0] LFSR_SEED  = 16'hACE1;

	localparam logic [1:0] KIND_SQUARE = 2'd0;
	localparam logic [1:0] KIND_PULSE  = 2'd1;
	localparam logic [1:0] KIND_NOISE  = 2'd2;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef struct packed {
		logic        op;
		logic [1:0]  instrument;
		logic [15:0] phase_step;
		logic [23:0] length_samples;
		logic [23:0] attack_samples;
		logic [23:0] decay_samples;
		logic [16:0] sustain_level;
		logic [23:0] release_samples;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               is_sample;
		logic               note_taken;
	} out_item_t;

	// per-voice record
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] step;
		logic [23:0] len;
		logic [23:0] att;
		logic [23:0] dec;
		logic [16:0] sus;
		logic [23:0] rel;
	} voice_cfg_t;

endpackage

### hw/rtl/multi_voice_tone_synth.sv
//------------------------------------------------------------------------------
// multi_voice_tone_synth
// Polyphonic square/pulse/noise synthesizer with envelope, top level.
//------------------------------------------------------------------------------
// Items go into a two-entry queue whenever busy is low; busy is high while both
// entries wait. Once it leaves the queue, a start item is picked up, the slots are
// scanned in order for the first free one, and the voice is loaded there. A tick
// walks each live voice in turn; a square voice inside its attack, decay or
// release ramp also waits for the envelope divider. Each result is shown on result
// for one cycle with strobe; the receiver cannot stall it and must take every
// transfer as it comes.
module multi_voice_tone_synth #(
	parameter int VOICES = mvts_pkg::VOICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mvts_pkg::in_item_t  cmd,
	output logic                busy,
	output logic                strobe,
	output mvts_pkg::out_item_t result
);
	import mvts_pkg::*;

	logic     q_valid, q_pop;
	in_item_t q_item;

	// intake queue
	mvts_front u_front (.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop));

	// voice engine
	mvts_engine #(.VOICES(VOICES)) u_engine (.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.strobe(strobe), .result(result));
endmodule

### hw/rtl/mvts_divider.sv
//------------------------------------------------------------------------------
// mvts_divider
// Restoring unsigned divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
module mvts_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [47:0] num,
	input  logic [23:0] den,
	output logic        done,
	output logic [47:0] quot
);
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [47:0] q_q;
	logic [24:0] r_q;
	logic [23:0] d_q;
	logic [24:0] trial;

	assign trial = {r_q[23:0], q_q[47]} - {1'b0, d_q};

	// shift one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (run_q) begin
			if (!trial[24]) begin
				r_q <= trial;
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				r_q <= {r_q[23:0], q_q[47]};
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
endmodule

### hw/rtl/mvts_front.sv
//------------------------------------------------------------------------------
// mvts_front
// Command intake: holds a two-entry queue of accepted items for the engine.
//------------------------------------------------------------------------------
module mvts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mvts_pkg::in_item_t cmd,
	output logic              busy,
	output logic              q_valid,
	output mvts_pkg::in_item_t q_item,
	input  logic              q_pop
);
	import mvts_pkg::*;

	in_item_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rp_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= cmd;
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count out of range");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !push) else $error("push while full");
endmodule

### hw/rtl/mvts_engine.sv
//------------------------------------------------------------------------------
// mvts_engine
// Voice sequencer: allocates slots on start, walks the mix order on tick.
//------------------------------------------------------------------------------
module mvts_engine #(
	parameter int VOICES = mvts_pkg::VOICES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  mvts_pkg::in_item_t q_item,
	output logic               q_pop,
	output logic               strobe,
	output mvts_pkg::out_item_t result
);
	import mvts_pkg::*;

	localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW = $clog2(VOICES + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_FIND = 4'd1;
	localparam logic [3:0] ST_LOAD = 4'd2;
	localparam logic [3:0] ST_RD   = 4'd3;
	localparam logic [3:0] ST_ENV  = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_POST = 4'd6;
	localparam logic [3:0] ST_MUL  = 4'd7;
	localparam logic [3:0] ST_ACC  = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;
	localparam logic [3:0] ST_SCAL = 4'd10;

	// envelope segments
	localparam logic [1:0] ENV_ATTACK  = 2'd0;
	localparam logic [1:0] ENV_DECAY   = 2'd1;
	localparam logic [1:0] ENV_RELEASE = 2'd2;
	localparam logic [1:0] ENV_SUSTAIN = 2'd3;

	// voice storage
	voice_cfg_t  cfg_mem [VOICES];
	logic [15:0] ph_mem  [VOICES];
	logic [23:0] el_mem  [VOICES];
	logic [VOICES-1:0] busy_q;
	logic [IW-1:0] order_q [VOICES];
	logic [CW-1:0] cnt_q, kept_q, idx_q;

	logic [3:0]  st_q;
	in_item_t    it_q;
	logic [IW-1:0] slot_q, v_q;
	voice_cfg_t  vc_q;
	logic [15:0] ph_s1;
	logic [23:0] el_s1;
	logic [1:0]  env_mode_q;
	logic [16:0] env_q;
	logic signed [47:0] sum_q;
	logic signed [16:0] fm_q;
	logic [15:0] lfsr_q;
	logic signed [17:0] val_q;
	logic [47:0] prod_q;

	// divider
	logic        dgo, ddone;
	logic [47:0] dnum, dquot;
	logic [23:0] dden;
	mvts_divider u_div (.clk(clk), .arst_n(arst_n), .go(dgo), .num(dnum), .den(dden),
		.done(ddone), .quot(dquot));

	// envelope segment bounds and the samples left before the note ends
	logic [24:0] a_plus_d;
	logic [24:0] t_plus_r;
	logic [23:0] rel_rem;
	assign a_plus_d = {1'b0, vc_q.att} + {1'b0, vc_q.dec};
	assign t_plus_r = {1'b0, el_s1} + {1'b0, vc_q.rel};
	assign rel_rem  = (vc_q.len > el_s1) ? (vc_q.len - el_s1) : 24'd0;

	logic signed [17:0] fdiff;
	logic signed [29:0] fprod;
	logic signed [16:0] fnew;
	logic               pulse_hi;
	assign pulse_hi = (ph_s1 + vc_q.step) < 16'h4000;
	assign fdiff = (pulse_hi ? 18'(PULSE_HI) : 18'(PULSE_LO)) - 18'(fm_q);
	assign fprod = 30'(fdiff) * $signed({1'b0, CUTOFF_Q15});
	assign fnew  = fm_q + 17'(fprod >>> 15);

	logic [15:0] lfsr_nx;
	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

	logic signed [59:0] vol;
	logic signed [43:0] vol_sh;
	assign vol = sum_q * $signed({1'b0, VOLUME_Q16});
	assign vol_sh = 44'(vol >>> 16);

	assign q_pop = (st_q == ST_IDLE) && q_valid;
	// start the divide once the segment is known, only for a square voice on a ramp
	assign dgo   = (st_q == ST_POST) && (vc_q.kind == KIND_SQUARE) &&
		(env_mode_q != ENV_SUSTAIN);

	always_comb begin
		dnum = '0;
		dden = vc_q.rel;
		unique case (env_mode_q)
			ENV_ATTACK: begin dnum = {8'd0, el_s1, 16'd0}; dden = vc_q.att; end
			ENV_DECAY: begin
				dnum = {8'd0, el_s1 - vc_q.att, 16'd0};
				dden = vc_q.dec;
			end
			default: begin
				dnum = 48'(rel_rem) * 48'(vc_q.sus);
				dden = vc_q.rel;
			end
		endcase
	end

	// sequence one item through its steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			busy_q <= '0;
			cnt_q  <= '0;
			fm_q   <= '0;
			lfsr_q <= LFSR_SEED;
			strobe <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (q_valid) begin
					it_q  <= q_item;
					idx_q <= '0;
					kept_q <= '0;
					sum_q <= '0;
					st_q  <= (q_item.op == OP_START) ? ST_FIND : ST_RD;
				end
				ST_FIND: begin
					if (idx_q == CW'(VOICES)) begin
						result <= '0;
						strobe <= 1'b1;
						st_q   <= ST_IDLE;
					end else if (!busy_q[idx_q[IW-1:0]]) begin
						slot_q <= idx_q[IW-1:0];
						st_q   <= ST_LOAD;
					end else idx_q <= idx_q + CW'(1);
				end
				ST_LOAD: begin
					busy_q[slot_q] <= 1'b1;
					for (int k = VOICES - 1; k > 0; k--) order_q[k] <= order_q[k-1];
					order_q[0] <= slot_q;
					cnt_q <= cnt_q + CW'(1);
					result <= '{sample: '0, is_sample: 1'b0, note_taken: 1'b1};
					strobe <= 1'b1;
					st_q <= ST_IDLE;
				end
				ST_RD: begin
					if (idx_q == cnt_q) begin
						st_q <= ST_SCAL;
					end else begin
						v_q  <= order_q[idx_q[IW-1:0]];
						st_q <= ST_ENV;
					end
				end
				ST_ENV: begin
					// classify envelope segment
					if ({1'b0, el_s1} < {1'b0, vc_q.att}) env_mode_q <= ENV_ATTACK;
					else if ({1'b0, el_s1} < a_plus_d) env_mode_q <= ENV_DECAY;
					else if (vc_q.rel != '0 && t_plus_r > {1'b0, vc_q.len})
						env_mode_q <= ENV_RELEASE;
					else env_mode_q <= ENV_SUSTAIN;
					st_q <= ST_POST;
				end
				ST_POST: begin
					if (vc_q.kind != KIND_SQUARE || env_mode_q == ENV_SUSTAIN) begin
						env_q <= vc_q.sus;
						st_q  <= ST_MUL;
					end else st_q <= ST_DIV;
				end
				ST_DIV: if (ddone) begin
					if (env_mode_q == ENV_DECAY)
						prod_q <= 48'(dquot[16:0]) * 48'(FULL_Q16 - vc_q.sus);
					else prod_q <= 48'(dquot[16:0]);
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					if (vc_q.kind == KIND_SQUARE && env_mode_q != ENV_SUSTAIN) begin
						env_q <= (env_mode_q == ENV_DECAY) ? (FULL_Q16 - prod_q[32:16])
							: prod_q[16:0];
					end
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					case (vc_q.kind)
						KIND_SQUARE: val_q <= (ph_s1 + vc_q.step) < 16'h8000 ?
							18'((34'(env_q) * AMP_Q16) >> 16) :
							-18'((34'(env_q) * AMP_Q16) >> 16);
						KIND_PULSE: begin
							fm_q  <= fnew;
							val_q <= {fnew, 1'b0};
						end
						KIND_NOISE: begin
							lfsr_q <= lfsr_nx;
							val_q  <= 18'(lfsr_nx) - 18'sd32768;
						end
						default: val_q <= '0;
					endcase
					if (el_s1 + 24'd1 >= vc_q.len) busy_q[v_q] <= 1'b0;
					else begin
						order_q[kept_q[IW-1:0]] <= v_q;
						kept_q <= kept_q + CW'(1);
					end
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					sum_q <= sum_q + 48'(val_q);
					idx_q <= idx_q + CW'(1);
					st_q  <= ST_RD;
				end
				ST_SCAL: begin
					cnt_q <= kept_q;
					result.is_sample  <= 1'b1;
					result.note_taken <= 1'b0;
					result.sample <= (vol_sh > 44'sd32767) ? 16'sh7fff :
						(vol_sh < -44'sd32768) ? -16'sh8000 : vol_sh[15:0];
					strobe <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// voice memories, registered reads
	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD) begin
			cfg_mem[slot_q] <= '{kind: it_q.instrument, step: it_q.phase_step,
				len: it_q.length_samples, att: it_q.attack_samples,
				dec: it_q.decay_samples,
				sus: (it_q.sustain_level > FULL_Q16) ? FULL_Q16 : it_q.sustain_level,
				rel: it_q.release_samples};
			ph_mem[slot_q] <= '0;
			el_mem[slot_q] <= '0;
		end
		// write back the advanced phase and sample count
		if (st_q == ST_ACC) begin
			ph_mem[v_q] <= ph_s1 + vc_q.step;
			el_mem[v_q] <= el_s1 + 24'd1;
		end
		if (st_q == ST_RD) begin
			vc_q  <= cfg_mem[order_q[idx_q[IW-1:0]]];
			ph_s1 <= ph_mem[order_q[idx_q[IW-1:0]]];
			el_s1 <= el_mem[order_q[idx_q[IW-1:0]]];
		end
	end

	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("back-to-back strobes");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> st_q != ST_IDLE) else $error("pop without leaving idle");
	a_lfsr_live: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != 16'd0) else $error("noise register stuck at zero");
endmodule

### tb/sv/tb_multi_voice_tone_synth.sv
//------------------------------------------------------------------------------
// tb_multi_voice_tone_synth
// Self-checking bench: a table of directed commands, then random note starts
// and ticks. Every sample and note grant is predicted and checked.
//------------------------------------------------------------------------------
module tb_multi_voice_tone_synth;
	timeunit 1ns;
	timeprecision 1ps;

	import mvts_pkg::*;

	localparam int NV        = VOICES_DEF;
	localparam int IDLE_MAX  = 200000;
	localparam int N_RANDOM  = 1300;

	logic        clk;
	logic        arst_n;
	logic        start;
	in_item_t    cmd;
	logic        busy;
	logic        strobe;
	out_item_t   result;

	multi_voice_tone_synth #(.VOICES(NV)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .strobe(strobe), .result(result)
	);

	// synthesizer state as the predictor sees it
	logic          v_busy[NV];
	logic [1:0]    v_kind[NV];
	logic [15:0]   v_phase[NV];
	logic [15:0]   v_step[NV];
	logic [23:0]   v_elapsed[NV];
	logic [23:0]   v_att[NV], v_dec[NV], v_rel[NV], v_len[NV];
	logic [16:0]   v_sus[NV];
	int            order[$];
	longint        filt_mem;
	logic [15:0]   lfsr;

	out_item_t     expected_out[$];
	int            errors;
	int            n_ticks, n_starts, n_taken, n_sat;
	int            idle_cycles;

	// one directed row: command plus an optional typed-in answer
	typedef struct {
		in_item_t  item;
		logic      has_answer;
		out_item_t answer;
	} row_t;
	row_t          rows[$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint floor_div_pow2(longint v, int k);
		if (v >= 0)
			return v >>> k;
		return -((-v + (64'sd1 << k) - 1) >>> k);
	endfunction

	function automatic longint env_level(int v);
		longint a, d, s, r, l, t, dd;
		a = v_att[v]; d = v_dec[v]; s = v_sus[v];
		r = v_rel[v]; l = v_len[v]; t = v_elapsed[v];
		if (t < a)
			return (t * 65536) / a;
		if (t < a + d) begin
			dd = ((t - a) * 65536) / d;
			return 65536 - ((dd * (65536 - s)) >>> 16);
		end
		if (r > 0 && t + r > l)
			return (((l > t) ? (l - t) : 0) * s) / r;
		return s;
	endfunction

	function automatic longint voice_contrib(int v);
		longint amp, x;
		logic   lsb;
		case (v_kind[v])
			KIND_SQUARE: begin
				amp = (env_level(v) * AMP_Q16) >>> 16;
				return (v_phase[v] < 16'h8000) ? amp : -amp;
			end
			KIND_PULSE: begin
				x = (v_phase[v] < 16'h4000) ? 32767 : -10813;
				filt_mem = filt_mem + floor_div_pow2((x - filt_mem) * 3277, 15);
				return filt_mem * 2;
			end
			KIND_NOISE: begin
				lsb = lfsr[0];
				lfsr = lfsr >> 1;
				if (lsb)
					lfsr = lfsr ^ LFSR_TAPS;
				return longint'(lfsr) - 32768;
			end
			default: return 0;
		endcase
	endfunction

	// compute the answer to one accepted command and advance the state
	function automatic out_item_t synth_answer(in_item_t it);
		out_item_t o;
		int        slot, v, kept[$];
		longint    sum, smp;
		o = '0;
		if (it.op == OP_START) begin
			slot = -1;
			for (int i = 0; i < NV; i++)
				if (!v_busy[i] && slot < 0)
					slot = i;
			if (slot >= 0) begin
				v_busy[slot]    = 1'b1;
				v_kind[slot]    = it.instrument;
				v_step[slot]    = it.phase_step;
				v_phase[slot]   = '0;
				v_elapsed[slot] = '0;
				v_len[slot]     = it.length_samples;
				v_att[slot]     = it.attack_samples;
				v_dec[slot]     = it.decay_samples;
				v_sus[slot]     = (it.sustain_level > FULL_Q16) ? FULL_Q16 : it.sustain_level;
				v_rel[slot]     = it.release_samples;
				order.push_front(slot);
				o.note_taken    = 1'b1;
			end
			return o;
		end
		sum = 0;
		foreach (order[i]) begin
			v = order[i];
			v_phase[v] = v_phase[v] + v_step[v];
			sum += voice_contrib(v);
			v_elapsed[v] = v_elapsed[v] + 24'd1;
			if (v_elapsed[v] >= v_len[v])
				v_busy[v] = 1'b0;
			else
				kept.push_back(v);
		end
		order = kept;
		smp = floor_div_pow2(sum * 3277, 16);
		if (smp > 32767 || smp < -32768)
			n_sat++;
		if (smp > 32767) smp = 32767;
		if (smp < -32768) smp = -32768;
		o.sample    = smp[15:0];
		o.is_sample = 1'b1;
		return o;
	endfunction

	function automatic in_item_t note_cmd(logic [1:0] kind, logic [15:0] stp, logic [23:0] len,
			logic [23:0] a, logic [23:0] d, logic [16:0] s, logic [23:0] r);
		in_item_t it;
		it.op = OP_START; it.instrument = kind; it.phase_step = stp;
		it.length_samples = len; it.attack_samples = a; it.decay_samples = d;
		it.sustain_level = s; it.release_samples = r;
		return it;
	endfunction

	function automatic in_item_t tick_cmd();
		in_item_t it;
		it = '0;
		it.op = OP_TICK;
		it.instrument = 2'($urandom_range(0, 3));
		it.phase_step = 16'($urandom);
		it.length_samples = 24'($urandom);
		return it;
	endfunction

	// random command: mostly short notes, a few long ones, many ticks
	function automatic in_item_t random_cmd();
		logic [23:0] len, a, d, r;
		logic [16:0] s;
		int          p;
		if ($urandom_range(0, 99) < 70)
			return tick_cmd();
		p = $urandom_range(0, 99);
		len = (p < 90) ? 24'($urandom_range(0, 40)) : 24'($urandom);
		a = (p < 50) ? 24'($urandom_range(0, 12)) : 24'($urandom);
		d = (p < 50) ? 24'($urandom_range(0, 12)) : 24'($urandom);
		r = (p < 50) ? 24'($urandom_range(0, 12)) : 24'($urandom);
		s = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
		return note_cmd(2'($urandom_range(0, 3)), 16'($urandom), len, a, d, s, r);
	endfunction

	task automatic add_row(in_item_t it, logic has, out_item_t ans);
		row_t rw;
		rw.item = it; rw.has_answer = has; rw.answer = ans;
		rows.push_back(rw);
	endtask

	// hold start until the transfer happens
	task automatic issue(in_item_t it, logic has, out_item_t ans);
		out_item_t pred;
		start <= 1'b1;
		cmd   <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pred = synth_answer(it);
		if (has && pred !== ans) begin
			$error("directed answer disagrees with predictor: %h vs %h", ans, pred);
			errors++;
		end
		expected_out.push_back(pred);
		if (it.op == OP_START) begin
			n_starts++;
			if (pred.note_taken) n_taken++;
		end else
			n_ticks++;
	endtask

	task automatic gap();
		int n;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) :
		    ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// check every result against the oldest expectation
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && strobe) begin
			if (expected_out.size() == 0) begin
				$error("unexpected result %h", result);
				errors++;
			end else begin
				e = expected_out.pop_front();
				if (result.sample !== e.sample) begin
					$error("sample: expected %0d actual %0d", e.sample, result.sample);
					errors++;
				end
				if (result.is_sample !== e.is_sample) begin
					$error("is_sample: expected %0b actual %0b", e.is_sample, result.is_sample);
					errors++;
				end
				if (result.note_taken !== e.note_taken) begin
					$error("note_taken: expected %0b actual %0b", e.note_taken,
						result.note_taken);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_MAX) begin
			$display("tb_multi_voice_tone_synth NOT OK");
			$finish;
		end
	end

	initial begin
		out_item_t z, tick0, taken, dropped;
		int        drain;
		errors = 0; n_ticks = 0; n_starts = 0; n_taken = 0; n_sat = 0;
		idle_cycles = 0;
		start  = 1'b0;
		cmd    = '0;
		arst_n = 1'b0;
		foreach (v_busy[i]) v_busy[i] = 1'b0;
		filt_mem = 0;
		lfsr = LFSR_SEED;
		z = '0;
		tick0 = '0; tick0.is_sample = 1'b1;
		taken = '0; taken.note_taken = 1'b1;
		dropped = '0;

		// directed table: silence after reset, extremes, voice exhaustion
		add_row(tick_cmd(), 1'b1, tick0);
		add_row(note_cmd(KIND_SQUARE, 16'h0000, 24'd0, 24'd0, 24'd0, 17'd0, 24'd0),
			1'b1, taken);
		add_row(tick_cmd(), 1'b0, z);
		add_row(note_cmd(KIND_SQUARE, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			17'h1FFFF, 24'hFFFFFF), 1'b1, taken);
		add_row(note_cmd(KIND_PULSE, 16'h1234, 24'd6, 24'd0, 24'd0, 17'd65536, 24'd0),
			1'b1, taken);
		add_row(note_cmd(KIND_NOISE, 16'hFFFF, 24'd5, 24'd2, 24'd2, 17'd30000, 24'd2),
			1'b1, taken);
		add_row(note_cmd(2'd3, 16'h8000, 24'd4, 24'd1, 24'd1, 17'd1, 24'd1), 1'b1, taken);
		add_row(note_cmd(KIND_SQUARE, 16'h0100, 24'd9, 24'd2, 24'd3, 17'd40000, 24'd4),
			1'b1, taken);
		add_row(tick_cmd(), 1'b0, z);
		add_row(tick_cmd(), 1'b0, z);
		for (int i = 0; i < 11; i++)
			add_row(note_cmd(KIND_SQUARE, 16'h7FFF, 24'd100, 24'd0, 24'd0, 17'd65536,
				24'd0), 1'b0, z);
		add_row(note_cmd(KIND_PULSE, 16'h0001, 24'd1, 24'd1, 24'd1, 17'd1, 24'd1),
			1'b1, dropped);
		add_row(tick_cmd(), 1'b0, z);
		add_row(tick_cmd(), 1'b0, z);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			issue(rows[i].item, rows[i].has_answer, rows[i].answer);
			gap();
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			issue(random_cmd(), 1'b0, z);
			gap();
		end
		start <= 1'b0;

		drain = 0;
		while (expected_out.size() != 0 && drain < IDLE_MAX) begin
			@(posedge clk);
			drain++;
		end
		repeat (2000) @(posedge clk);
		if (expected_out.size() != 0) begin
			$error("%0d results never arrived", expected_out.size());
			errors++;
		end

		$display("covered %0d ticks, %0d note starts (%0d granted), %0d saturated samples",
			n_ticks, n_starts, n_taken, n_sat);
		if (errors == 0)
			$display("tb_multi_voice_tone_synth OK");
		else
			$display("tb_multi_voice_tone_synth NOT OK");
		$finish;
	end

endmodule
